### hdl/bile_pkg.sv
// Package for the bounded integer list engine.
// Holds request and response item types, operation and status codes, cell control struct.
// No dependencies.
package bile_pkg;

	localparam logic [2:0] FUNC_PUSH     = 3'd0;
	localparam logic [2:0] FUNC_POP      = 3'd1;
	localparam logic [2:0] FUNC_REMOVE   = 3'd2;
	localparam logic [2:0] FUNC_GET      = 3'd3;
	localparam logic [2:0] FUNC_CONTAINS = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_INDEX = 2'd3;

	// one request item
	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
		logic [6:0]         index;
	} req_item_t;

	// one response item
	typedef struct packed {
		logic signed [31:0] data;
		logic               found;
		logic [1:0]         status;
		logic [7:0]         count;
	} rsp_item_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic capture;   // request accepted this cycle
		logic push;      // append at the old count
		logic remove;    // close the gap at index
		logic contains;  // compare live entries with value
		logic read_en;   // pick the entry at read_pos
		logic sweep;     // fold the neighbor's result toward cell 0
	} cell_ctrl_t;

endpackage

### hdl/bile_cell.sv
// One list cell: holds one entry and one partial result.
// Uses bile_pkg (cell_ctrl_t); chained by bounded_int_list_engine.
module bile_cell #(
	parameter int POS = 0,
	parameter int CW  = 8
) (
	input  logic                   clk,
	input  bile_pkg::cell_ctrl_t   ctrl,
	input  logic [31:0]            value,
	input  logic [CW-1:0]          count_old,
	input  logic [CW-1:0]          index,
	input  logic [CW-1:0]          read_pos,
	input  logic [31:0]            next_entry,
	input  logic [32:0]            next_acc,
	output logic [31:0]            entry,
	output logic [32:0]            acc
);

	localparam logic [CW-1:0] POS_C  = CW'(POS);
	localparam logic [CW-1:0] NEXT_C = CW'(POS + 1);

	logic [31:0] entry_q;
	logic [32:0] acc_q;
	logic        hit;
	logic        pick;

	assign hit  = ctrl.contains && (POS_C < count_old) && (entry_q == value);
	assign pick = ctrl.read_en && (POS_C == read_pos);

	always_ff @(posedge clk) begin
		if (ctrl.push && (POS_C == count_old)) begin
			entry_q <= value;
		end else if (ctrl.remove && (POS_C >= index) && (NEXT_C < count_old)) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			acc_q <= {hit, pick ? entry_q : 32'd0};
		end else if (ctrl.sweep) begin
			acc_q <= acc_q | next_acc;
		end
	end

	assign entry = entry_q;
	assign acc   = acc_q;

endmodule

### hdl/bounded_int_list_engine.sv
// Top level of the bounded integer list engine: sequencer, cell chain, response register.
// Uses bile_pkg and bile_cell.
//
// Usage:
//  Request channel (req_valid / req_stall / req) carries one operation item:
//  push, pop, remove at index, get at index, or contains. Response channel
//  (rsp_valid / rsp_stall / rsp) returns exactly one item per request with
//  data, found flag, status and the live count after the operation.
//  The list lives in a chain of CAPACITY cells, one entry per cell. On accept
//  every cell acts at once: push loads the cell at the count, remove makes
//  each cell from the index upward take its upper neighbor's entry. The cells
//  also capture a partial answer, which then folds toward cell 0 one cell per
//  cycle until the needed position is covered.
//  The sweep down the cell chain runs until its counter reaches a limit:
//  zero for push, remove, errors and empty contains; the position read for
//  pop and get; count-1 for contains. One item is in work at a time;
//  req_stall is high from accept until the result is loaded into the
//  response register.
//  The response register holds while rsp_stall is high; the sweep then waits
//  at its end. Reset clears the count and control state; entries are left as
//  they are and are only read once written.
module bounded_int_list_engine #(
	parameter int CAPACITY = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bile_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bile_pkg::rsp_item_t rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_SWEEP = 2'b10
	} state_t;

	state_t               st_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        limit_q;
	logic [CW-1:0]        cnt_q;
	logic [1:0]           status_q;
	logic                 rsp_valid_q;
	bile_pkg::rsp_item_t  rsp_q;

	logic                 accept;
	logic                 out_free;
	logic                 rsp_load;
	logic                 is_push, is_pop, is_remove, is_get, is_contains;
	logic                 full, empty, idx_ok;
	logic                 push_ok, pop_ok, rem_ok, get_ok;
	logic [CW-1:0]        idx_c;
	logic [CW-1:0]        last_c;
	logic [CW-1:0]        read_pos;
	logic [CW-1:0]        limit_d;
	logic [CW-1:0]        count_d;
	logic [1:0]           status_d;
	logic                 sweep_done;
	bile_pkg::cell_ctrl_t ctrl;

	logic [31:0] entry_w [CAPACITY];
	logic [32:0] acc_w   [CAPACITY];

	// handshake
	assign req_stall = (st_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// decode
	assign is_push     = (req.func == bile_pkg::FUNC_PUSH);
	assign is_pop      = (req.func == bile_pkg::FUNC_POP);
	assign is_remove   = (req.func == bile_pkg::FUNC_REMOVE);
	assign is_get      = (req.func == bile_pkg::FUNC_GET);
	assign is_contains = (req.func == bile_pkg::FUNC_CONTAINS);

	assign full   = (count_q == CAP_C);
	assign empty  = (count_q == '0);
	assign idx_ok = (CMPW'(req.index) < CMPW'(count_q));
	assign idx_c  = CW'(req.index);    // only used when below the count
	assign last_c = count_q - ONE_C;

	assign push_ok = is_push && !full;
	assign pop_ok  = is_pop && !empty;
	assign rem_ok  = is_remove && idx_ok;
	assign get_ok  = is_get && idx_ok;

	assign read_pos = is_pop ? last_c : idx_c;

	always_comb begin
		priority if (is_push && full) begin
			status_d = bile_pkg::STATUS_FULL;
		end else if (is_pop && empty) begin
			status_d = bile_pkg::STATUS_EMPTY;
		end else if ((is_remove || is_get) && !idx_ok) begin
			status_d = bile_pkg::STATUS_INDEX;
		end else begin
			status_d = bile_pkg::STATUS_OK;
		end
	end

	always_comb begin
		priority if (push_ok) begin
			count_d = count_q + ONE_C;
		end else if (pop_ok || rem_ok) begin
			count_d = last_c;
		end else begin
			count_d = count_q;
		end
	end

	// how far the answer must travel down the chain
	always_comb begin
		priority if (pop_ok || (is_contains && !empty)) begin
			limit_d = last_c;
		end else if (get_ok) begin
			limit_d = idx_c;
		end else begin
			limit_d = '0;
		end
	end

	assign sweep_done = (cnt_q == limit_q);
	assign rsp_load   = (st_q == S_SWEEP) && sweep_done && out_free;

	always_comb begin
		ctrl.capture  = accept;
		ctrl.push     = accept && push_ok;
		ctrl.remove   = accept && rem_ok;
		ctrl.contains = accept && is_contains;
		ctrl.read_en  = accept && (pop_ok || get_ok);
		ctrl.sweep    = (st_q == S_SWEEP) && !sweep_done;
	end

	// cell chain; the top cell sees an empty neighbor
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [31:0] nxt_entry;
		logic [32:0] nxt_acc;

		if (g == CAPACITY - 1) begin : g_top
			assign nxt_entry = '0;
			assign nxt_acc   = '0;
		end else begin : g_mid
			assign nxt_entry = entry_w[g+1];
			assign nxt_acc   = acc_w[g+1];
		end

		bile_cell #(
			.POS (g),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (req.value),
			.count_old  (count_q),
			.index      (idx_c),
			.read_pos   (read_pos),
			.next_entry (nxt_entry),
			.next_acc   (nxt_acc),
			.entry      (entry_w[g]),
			.acc        (acc_w[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			limit_q     <= '0;
			cnt_q       <= '0;
			status_q    <= bile_pkg::STATUS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			// a load replaces the item leaving in the same cycle
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						count_q  <= count_d;
						limit_q  <= limit_d;
						status_q <= status_d;
						cnt_q    <= '0;
						st_q     <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (!sweep_done) begin
						cnt_q <= cnt_q + ONE_C;
					end else if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.data   <= acc_w[0][31:0];
			rsp_q.found  <= acc_w[0][32];
			rsp_q.status <= status_q;
			rsp_q.count  <= 8'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
